// ===== rtl/core/gain_fade_ramp_defines.svh =====
// ----------------------------------------------------------------------------
// Gain fade ramp assertion macros
// Concurrent assertion shorthands, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef GAIN_FADE_RAMP_DEFINES_SVH
`define GAIN_FADE_RAMP_DEFINES_SVH

// same-cycle implication
`define GFR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Gain fade ramp package
// Widths, codes, shared types and helpers for the gain fade ramp block.
// ----------------------------------------------------------------------------
`default_nettype none

package gfr_pkg;

  localparam int GAIN_W   = 16;
  localparam int TIME_W   = 32;
  localparam int DT_W     = 20;
  localparam int DUR_W    = 24;
  localparam int PROD_W   = TIME_W + GAIN_W;
  localparam int MODE_W   = 2;
  localparam int FADE_W   = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int REG_BIT  = 2;

  localparam int MUL_STEPS = GAIN_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OUT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

  localparam logic [FADE_W-1:0] FADE_IDLE = 2'd0;
  localparam logic [FADE_W-1:0] FADE_IN   = 2'd1;
  localparam logic [FADE_W-1:0] FADE_DOWN = 2'd2;

  localparam logic REG_MAX_GAIN = 1'b0;
  localparam logic REG_MIN_GAIN = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = 16'h8000;
  localparam logic [GAIN_W-1:0] GAIN_ZERO = 16'h0000;

  typedef struct packed {
    logic [GAIN_W-1:0] max_gain;
    logic [GAIN_W-1:0] min_gain;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] a;
    logic [GAIN_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  function automatic logic [TIME_W-1:0] sat32(input logic [PROD_W-1:0] v);
    return (|v[PROD_W-1:TIME_W]) ? {TIME_W{1'b1}} : v[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gain_fade_ramp.sv =====
// ----------------------------------------------------------------------------
// Gain fade ramp
// Linear gain fade engine: ticks advance the ramp, fade commands start or
// rescale it. Sequencer around a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                   Payload
// cfg       in         psel/penable/pwrite/pready  paddr, pwdata, prdata
// in        in         in_valid_i/in_ready_o       mode, delta_time, fade_duration,
//                                                  playing, has_source
// out       out        out_valid_o/out_ready_i     gain_out, fade_state, accepted,
//                                                  play_request
//
// One transaction in flight; the next is taken in the cycle after a result is loaded.
// Running tick with a nonzero fade length: result after a multiply then a divide.
// Rescaling fade command: up to two multiply and divide passes.
// All other transactions: result straight from decode, with no multiply or divide.
// Reset: gain 1.0, no fade, zero times, max gain 1.0, min gain 0.
// A stalled output holds the finished transaction in the final state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gain_fade_ramp_defines.svh"

module gain_fade_ramp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gfr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [gfr_pkg::DATA_W-1:0]  pwdata,
  output logic      [gfr_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [gfr_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [gfr_pkg::DT_W-1:0]    delta_time_i,
  input  wire logic [gfr_pkg::DUR_W-1:0]   fade_duration_i,
  input  wire logic                        playing_i,
  input  wire logic                        has_source_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [gfr_pkg::GAIN_W-1:0]  gain_out_o,
  output logic      [gfr_pkg::FADE_W-1:0]  fade_state_o,
  output logic                             accepted_o,
  output logic                             play_request_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_A,
    ST_DIV_A,
    ST_MUL_B,
    ST_DIV_B,
    ST_FIN
  } state_e;

  state_e                     state_q;
  gfr_pkg::cfg_t              cfg;
  gfr_pkg::mul_req_t          mul_req_q;
  gfr_pkg::div_req_t          div_req_q;
  logic                       mul_done;
  logic                       div_done;
  logic [gfr_pkg::PROD_W-1:0] mul_prod;
  logic [gfr_pkg::PROD_W-1:0] div_quo;

  logic [gfr_pkg::MODE_W-1:0] mode_q;
  logic [gfr_pkg::DT_W-1:0]   dt_q;
  logic [gfr_pkg::DUR_W-1:0]  dur_q;
  logic                       play_q;
  logic                       src_q;

  logic [gfr_pkg::GAIN_W-1:0] gain_q;
  logic [gfr_pkg::FADE_W-1:0] fmode_q;
  logic [gfr_pkg::TIME_W-1:0] flen_q;
  logic [gfr_pkg::TIME_W-1:0] elap_q;
  logic [gfr_pkg::GAIN_W-1:0] dfar_q;
  logic [gfr_pkg::GAIN_W-1:0] dnear_q;
  logic                       near_q;
  logic                       acc_q;
  logic                       req_q;

  logic                       out_valid_q;
  logic [gfr_pkg::GAIN_W-1:0] out_gain_q;
  logic [gfr_pkg::FADE_W-1:0] out_fade_q;
  logic                       out_acc_q;
  logic                       out_req_q;

  logic [gfr_pkg::GAIN_W-1:0] lo;
  logic [gfr_pkg::GAIN_W-1:0] hi;
  logic [gfr_pkg::GAIN_W-1:0] span;
  logic [gfr_pkg::TIME_W:0]   elap_sum;
  logic [gfr_pkg::TIME_W-1:0] elap_new;
  logic [gfr_pkg::TIME_W-1:0] quo_sat;
  logic                       over;
  logic                       tick_run;
  logic                       in_resc;
  logic                       out_resc;
  logic                       far_ok;
  logic                       near_ok;
  logic [gfr_pkg::GAIN_W-1:0] dist_far;
  logic [gfr_pkg::GAIN_W-1:0] dist_near;
  logic                       far_go;
  logic [gfr_pkg::TIME_W-1:0] dur_ext;
  logic                       mul_wait;
  logic                       div_wait;

  gfr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gfr_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req_q),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  gfr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    hi       = cfg.max_gain;
    lo       = (cfg.min_gain > cfg.max_gain) ? cfg.max_gain : cfg.min_gain;
    span     = hi - lo;
    elap_sum = {1'b0, elap_q} + {{(gfr_pkg::TIME_W + 1 - gfr_pkg::DT_W){1'b0}}, dt_q};
    elap_new = elap_sum[gfr_pkg::TIME_W] ? {gfr_pkg::TIME_W{1'b1}}
                                         : elap_sum[gfr_pkg::TIME_W-1:0];
    quo_sat  = gfr_pkg::sat32(div_quo);
    over     = (|div_quo[gfr_pkg::PROD_W-1:gfr_pkg::GAIN_W]) ||
               (div_quo[gfr_pkg::GAIN_W-1:0] > span);
    dur_ext  = {{(gfr_pkg::TIME_W - gfr_pkg::DUR_W){1'b0}}, dur_q};
    tick_run = src_q && ((fmode_q == gfr_pkg::FADE_IN) || (fmode_q == gfr_pkg::FADE_DOWN));
    in_resc  = play_q && (gain_q != hi) &&
               ((fmode_q == gfr_pkg::FADE_IDLE) || (fmode_q == gfr_pkg::FADE_DOWN));
    out_resc = play_q && (gain_q != lo) &&
               ((fmode_q == gfr_pkg::FADE_IDLE) || (fmode_q == gfr_pkg::FADE_IN));
    if (mode_q == gfr_pkg::MODE_IN) begin
      far_ok    = gain_q < hi;
      dist_far  = hi - gain_q;
      near_ok   = gain_q >= lo;
      dist_near = gain_q - lo;
    end else begin
      far_ok    = gain_q > lo;
      dist_far  = gain_q - lo;
      near_ok   = gain_q <= hi;
      dist_near = hi - gain_q;
    end
    far_go = far_ok && (dist_far != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_req_q   <= '0;
      div_req_q   <= '0;
      mode_q      <= gfr_pkg::MODE_TICK;
      dt_q        <= '0;
      dur_q       <= '0;
      play_q      <= 1'b0;
      src_q       <= 1'b0;
      gain_q      <= gfr_pkg::GAIN_ONE;
      fmode_q     <= gfr_pkg::FADE_IDLE;
      flen_q      <= '0;
      elap_q      <= '0;
      dfar_q      <= '0;
      dnear_q     <= '0;
      near_q      <= 1'b0;
      acc_q       <= 1'b0;
      req_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_gain_q  <= '0;
      out_fade_q  <= gfr_pkg::FADE_IDLE;
      out_acc_q   <= 1'b0;
      out_req_q   <= 1'b0;
    end else begin
      mul_req_q.start <= 1'b0;
      div_req_q.start <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_i;
            dt_q    <= delta_time_i;
            dur_q   <= fade_duration_i;
            play_q  <= playing_i;
            src_q   <= has_source_i;
            state_q <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          acc_q   <= 1'b0;
          req_q   <= 1'b0;
          state_q <= ST_FIN;
          unique case (mode_q)
            gfr_pkg::MODE_TICK: begin
              if (tick_run) begin
                elap_q <= elap_new;
                if (flen_q == '0) begin
                  gain_q  <= (fmode_q == gfr_pkg::FADE_IN) ? hi : lo;
                  fmode_q <= gfr_pkg::FADE_IDLE;
                end else begin
                  mul_req_q <= '{start: 1'b1, a: elap_new, b: span};
                  state_q   <= ST_MUL_A;
                end
              end
            end
            gfr_pkg::MODE_IN, gfr_pkg::MODE_OUT: begin
              if ((mode_q == gfr_pkg::MODE_IN) ? in_resc : out_resc) begin
                fmode_q <= (mode_q == gfr_pkg::MODE_IN) ? gfr_pkg::FADE_IN
                                                         : gfr_pkg::FADE_DOWN;
                acc_q   <= 1'b1;
                if (!far_go) begin
                  flen_q <= dur_ext;
                  elap_q <= dur_ext;
                end else begin
                  dfar_q    <= dist_far;
                  dnear_q   <= dist_near;
                  near_q    <= near_ok && (span != '0);
                  mul_req_q <= '{start: 1'b1, a: dur_ext, b: span};
                  state_q   <= ST_MUL_A;
                end
              end else if (mode_q == gfr_pkg::MODE_IN) begin
                fmode_q <= gfr_pkg::FADE_IN;
                flen_q  <= dur_ext;
                elap_q  <= '0;
                gain_q  <= lo;
                req_q   <= 1'b1;
                acc_q   <= play_q;
              end
            end
            default: ;
          endcase
        end

        ST_MUL_A: begin
          if (mul_done) begin
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= mul_prod;
            div_req_q.divisor  <= (mode_q == gfr_pkg::MODE_TICK) ? flen_q
                : {{(gfr_pkg::TIME_W - gfr_pkg::GAIN_W){1'b0}}, dfar_q};
            state_q <= ST_DIV_A;
          end
        end

        ST_DIV_A: begin
          if (div_done) begin
            state_q <= ST_FIN;
            if (mode_q == gfr_pkg::MODE_TICK) begin
              if (over) begin
                gain_q  <= (fmode_q == gfr_pkg::FADE_IN) ? hi : lo;
                fmode_q <= gfr_pkg::FADE_IDLE;
              end else begin
                gain_q <= (fmode_q == gfr_pkg::FADE_IN)
                          ? lo + div_quo[gfr_pkg::GAIN_W-1:0]
                          : hi - div_quo[gfr_pkg::GAIN_W-1:0];
              end
            end else begin
              flen_q <= quo_sat;
              if (near_q) begin
                mul_req_q <= '{start: 1'b1, a: quo_sat, b: dnear_q};
                state_q   <= ST_MUL_B;
              end else begin
                elap_q <= '0;
              end
            end
          end
        end

        ST_MUL_B: begin
          if (mul_done) begin
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= mul_prod;
            div_req_q.divisor  <= {{(gfr_pkg::TIME_W - gfr_pkg::GAIN_W){1'b0}}, span};
            state_q            <= ST_DIV_B;
          end
        end

        ST_DIV_B: begin
          if (div_done) begin
            elap_q  <= quo_sat;
            state_q <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_gain_q  <= gain_q;
            out_fade_q  <= fmode_q;
            out_acc_q   <= acc_q;
            out_req_q   <= req_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign gain_out_o     = out_gain_q;
  assign fade_state_o   = out_fade_q;
  assign accepted_o     = out_acc_q;
  assign play_request_o = out_req_q;

  assign mul_wait = (state_q == ST_MUL_A) || (state_q == ST_MUL_B);
  assign div_wait = (state_q == ST_DIV_A) || (state_q == ST_DIV_B);

  `GFR_ASSERT_NXT(a_accept_decode, in_valid_i && in_ready_o, state_q == ST_DECODE, "no decode")
  `GFR_ASSERT_IMP(a_mul_done_state, mul_done, mul_wait, "product outside a multiply state")
  `GFR_ASSERT_IMP(a_div_done_state, div_done, div_wait, "quotient outside a divide state")
  `GFR_ASSERT_IMP(a_out_from_fin, $rose(out_valid_o), $past(state_q == ST_FIN), "stray result")

endmodule

`default_nettype wire

// ===== rtl/core/gfr_cfg.sv =====
// ----------------------------------------------------------------------------
// Gain fade ramp register file
// APB-style access to the gain limit registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gfr_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gfr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [gfr_pkg::DATA_W-1:0] pwdata,
  output logic      [gfr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output gfr_pkg::cfg_t                   cfg_o
);

  logic [gfr_pkg::GAIN_W-1:0] max_gain_q;
  logic [gfr_pkg::GAIN_W-1:0] min_gain_q;
  logic                       wr_en;
  logic                       reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[gfr_pkg::REG_BIT];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gain_q <= gfr_pkg::GAIN_ONE;
      min_gain_q <= gfr_pkg::GAIN_ZERO;
    end else if (wr_en) begin
      unique case (reg_sel)
        gfr_pkg::REG_MAX_GAIN: max_gain_q <= pwdata[gfr_pkg::GAIN_W-1:0];
        gfr_pkg::REG_MIN_GAIN: min_gain_q <= pwdata[gfr_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gfr_pkg::REG_MAX_GAIN:
        prdata = {{(gfr_pkg::DATA_W-gfr_pkg::GAIN_W){1'b0}}, max_gain_q};
      default:
        prdata = {{(gfr_pkg::DATA_W-gfr_pkg::GAIN_W){1'b0}}, min_gain_q};
    endcase
  end

  assign cfg_o.max_gain = max_gain_q;
  assign cfg_o.min_gain = min_gain_q;

endmodule

`default_nettype wire

// ===== rtl/core/gfr_mul.sv =====
// ----------------------------------------------------------------------------
// Gain fade ramp serial multiplier
// Shift-add multiplier, one bit of the gain operand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gfr_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gfr_pkg::mul_req_t             req_i,
  output logic                               done_o,
  output logic      [gfr_pkg::PROD_W-1:0]    prod_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [gfr_pkg::MUL_CNT_W-1:0] cnt_q;
  logic [gfr_pkg::TIME_W-1:0]    a_q;
  logic [gfr_pkg::TIME_W-1:0]    hi_q;
  logic [gfr_pkg::GAIN_W-1:0]    lo_q;
  logic [gfr_pkg::TIME_W-1:0]    addend;
  logic [gfr_pkg::TIME_W:0]      sum;

  assign addend = lo_q[0] ? a_q : '0;
  assign sum    = {1'b0, hi_q} + {1'b0, addend};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= req_i.a;
      hi_q   <= '0;
      lo_q   <= req_i.b;
    end else if (busy_q) begin
      hi_q  <= sum[gfr_pkg::TIME_W:1];
      lo_q  <= {sum[0], lo_q[gfr_pkg::GAIN_W-1:1]};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == gfr_pkg::MUL_CNT_W'(gfr_pkg::MUL_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

// ===== rtl/core/gfr_div.sv =====
// ----------------------------------------------------------------------------
// Gain fade ramp serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gfr_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gfr_pkg::div_req_t             req_i,
  output logic                               done_o,
  output logic      [gfr_pkg::PROD_W-1:0]    quo_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [gfr_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [gfr_pkg::PROD_W-1:0]    dvd_q;
  logic [gfr_pkg::TIME_W-1:0]    rem_q;
  logic [gfr_pkg::TIME_W-1:0]    dvs_q;
  logic [gfr_pkg::TIME_W:0]      part;
  logic [gfr_pkg::TIME_W:0]      trial;
  logic                          ge;

  assign part  = {rem_q, dvd_q[gfr_pkg::PROD_W-1]};
  assign trial = part - {1'b0, dvs_q};
  assign ge    = part >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= req_i.dividend;
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? trial[gfr_pkg::TIME_W-1:0] : part[gfr_pkg::TIME_W-1:0];
      dvd_q <= {dvd_q[gfr_pkg::PROD_W-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == gfr_pkg::DIV_CNT_W'(gfr_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

`default_nettype wire
